FILE: hdl/fcp_pkg.sv
// Package for the XOR-checked frame parser: phase and result types, header constants.
`timescale 1ns / 1ps
`default_nettype none

package fcp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT_U   = 3'd0,
        PH_EXPECT_N = 3'd1,
        PH_EXPECT_E = 3'd2,
        PH_EXPECT_R = 3'd3,
        PH_LENGTH   = 3'd4,
        PH_COLON    = 3'd5,
        PH_COMMAND  = 3'd6,
        PH_BODY     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CMD     = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_GOOD    = 2'd2,
        KIND_BAD     = 2'd3
    } kind_t;

    typedef struct packed {
        logic       vld;
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    localparam logic [7:0] HDR_U = 8'h55;
    localparam logic [7:0] HDR_N = 8'h4E;
    localparam logic [7:0] HDR_E = 8'h45;
    localparam logic [7:0] HDR_R = 8'h52;
    localparam logic [7:0] SEP_COLON = 8'h3A;

endpackage

`default_nettype wire

FILE: hdl/xor_checked_frame_parser.sv
// Top level of the XOR-checked frame parser: byte in, command/payload/report out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   input   | in        | in_valid / in_stall  | rx_byte[7:0]
//   output  | out       | out_valid / out_stall| kind[1:0], data[7:0]
//
// One byte is taken per cycle while in_stall is low; its result, if any, shows on
// the output in the cycle after it is taken, from the result register.
// in_stall is high only while a result is held and out_stall is high; a byte
// taken in the same cycle the held result leaves replaces it.
// rst_n clears the parse phase, counters, XOR and the result valid at once.
// Header, length and ':' bytes give no result; command and payload bytes give
// one each, and the check byte gives a good or bad report.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_frame_parser (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      data
);

    fcp_pkg::result_t result;
    fcp_pkg::kind_t   out_kind;
    logic             busy;
    logic             accept;

    assign in_stall = busy;
    assign accept   = in_valid & ~busy;

    // phase machine and running XOR
    fcp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .result  (result)
    );

    // result register parts the two handshakes
    fcp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_kind  (out_kind),
        .out_data  (data),
        .busy      (busy)
    );

    assign kind = out_kind;

endmodule

`default_nettype wire

FILE: hdl/fcp_parser.sv
// Frame parser state machine: header hunt, length, command, payload and XOR check.
`timescale 1ns / 1ps
`default_nettype none

module fcp_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    output fcp_pkg::result_t     result
);

    fcp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] command_code_reg, command_code_next;

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        bytes_left_next   = bytes_left_reg;
        running_xor_next  = running_xor_reg;
        command_code_next = command_code_reg;
        if (accept)
        begin
            case (phase_reg)
                fcp_pkg::PH_HUNT_U:
                begin
                    if (rx_byte == fcp_pkg::HDR_U)
                    begin
                        running_xor_next = rx_byte;
                        phase_next       = fcp_pkg::PH_EXPECT_N;
                    end
                end
                fcp_pkg::PH_EXPECT_N:
                begin
                    if (rx_byte == fcp_pkg::HDR_N)
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        phase_next       = fcp_pkg::PH_EXPECT_E;
                    end
                    else
                        phase_next = fcp_pkg::PH_HUNT_U;
                end
                fcp_pkg::PH_EXPECT_E:
                begin
                    if (rx_byte == fcp_pkg::HDR_E)
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        phase_next       = fcp_pkg::PH_EXPECT_R;
                    end
                    else
                        phase_next = fcp_pkg::PH_HUNT_U;
                end
                fcp_pkg::PH_EXPECT_R:
                begin
                    if (rx_byte == fcp_pkg::HDR_R)
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        phase_next       = fcp_pkg::PH_LENGTH;
                    end
                    else
                        phase_next = fcp_pkg::PH_HUNT_U;
                end
                fcp_pkg::PH_LENGTH:
                begin
                    frame_length_next = rx_byte;
                    running_xor_next  = running_xor_reg ^ rx_byte;
                    phase_next        = fcp_pkg::PH_COLON;
                end
                fcp_pkg::PH_COLON:
                begin
                    if (rx_byte == fcp_pkg::SEP_COLON)
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        phase_next       = fcp_pkg::PH_COMMAND;
                    end
                    else
                        phase_next = fcp_pkg::PH_HUNT_U;
                end
                fcp_pkg::PH_COMMAND:
                begin
                    command_code_next = rx_byte;
                    running_xor_next  = running_xor_reg ^ rx_byte;
                    bytes_left_next   = frame_length_reg;
                    phase_next        = fcp_pkg::PH_BODY;
                end
                fcp_pkg::PH_BODY:
                begin
                    if (bytes_left_reg != 8'd0)
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        bytes_left_next  = bytes_left_reg - 8'd1;
                    end
                    else
                        phase_next = fcp_pkg::PH_HUNT_U;
                end
                default:
                    phase_next = fcp_pkg::PH_HUNT_U;
            endcase
        end
    end

    // result for the item taken this cycle
    always_comb
    begin
        result.vld  = 1'b0;
        result.kind = fcp_pkg::KIND_CMD;
        result.data = rx_byte;
        case (phase_reg)
            fcp_pkg::PH_COMMAND:
                result.vld = accept;
            fcp_pkg::PH_BODY:
            begin
                result.vld = accept;
                if (bytes_left_reg != 8'd0)
                    result.kind = fcp_pkg::KIND_PAYLOAD;
                else
                begin
                    result.kind = (running_xor_reg == rx_byte) ? fcp_pkg::KIND_GOOD
                                                               : fcp_pkg::KIND_BAD;
                    result.data = command_code_reg;
                end
            end
            default:
                result.vld = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= fcp_pkg::PH_HUNT_U;
            frame_length_reg <= 8'd0;
            bytes_left_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            command_code_reg <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            bytes_left_reg   <= bytes_left_next;
            running_xor_reg  <= running_xor_next;
            command_code_reg <= command_code_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fcp_out_reg.sv
// Result register for the frame parser output channel.
`timescale 1ns / 1ps
`default_nettype none

module fcp_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fcp_pkg::result_t result,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output fcp_pkg::kind_t        out_kind,
    output logic [7:0]            out_data,
    output logic                  busy
);

    logic           valid_reg, valid_next;
    fcp_pkg::kind_t kind_reg, kind_next;
    logic [7:0]     data_reg, data_next;

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        if (result.vld)
        begin
            valid_next = 1'b1;
            kind_next  = result.kind;
            data_next  = result.data;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    // held result not yet taken: no room for a new one
    assign busy      = valid_reg & out_stall;

endmodule

`default_nettype wire

FILE: hdl/fcp_checker.sv
// Port-level checker for the frame parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fcp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] data
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data))
        else $error("stalled result changed");

    // input backpressure only from a held, stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // a new result needs a byte taken the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall))
        else $error("result appeared without an input item");

    // taken result with no new byte leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result repeated");

endmodule

bind xor_checked_frame_parser fcp_checker u_fcp_checker (.*);

`default_nettype wire

FILE: dv/xor_checked_frame_parser_tb.sv
// Testbench for the XOR-checked frame parser: directed and random byte streams, scoreboard.
`timescale 1ns / 1ps

module xor_checked_frame_parser_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 360;
    localparam int STEADY_ITEMS = 80;
    localparam int DRAIN_CYCLES = 8;

    // One parsed output item: what the block reports for one received byte.
    typedef struct packed {
        fcp_pkg::kind_t kind;
        logic [7:0]     data;
    } parsed_item_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [1:0] kind;
    logic [7:0] data;

    // Shadow copy of the parser state.
    fcp_pkg::phase_t sh_phase;
    logic [7:0]      sh_length;
    logic [7:0]      sh_left;
    logic [7:0]      sh_xor;
    logic [7:0]      sh_cmd;

    parsed_item_t parsed_q[$];

    int  errors      = 0;
    int  cycle_count = 0;
    int  byte_count  = 0;
    int  stall_left  = 0;
    bit  idle_en     = 1'b0;

    xor_checked_frame_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .data     (data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Parser prediction for one accepted byte; pushes the expected item, if any.
    task automatic predict_parse(input logic [7:0] b);
        logic [7:0]   want;
        parsed_item_t item;
        want = 8'h00;
        case (sh_phase)
            fcp_pkg::PH_HUNT_U:
            begin
                // anything but 'U' is dropped silently
                if (b == fcp_pkg::HDR_U)
                begin
                    sh_xor   = b;
                    sh_phase = fcp_pkg::PH_EXPECT_N;
                end
            end
            fcp_pkg::PH_EXPECT_N, fcp_pkg::PH_EXPECT_E, fcp_pkg::PH_EXPECT_R,
            fcp_pkg::PH_COLON:
            begin
                case (sh_phase)
                    fcp_pkg::PH_EXPECT_N: want = fcp_pkg::HDR_N;
                    fcp_pkg::PH_EXPECT_E: want = fcp_pkg::HDR_E;
                    fcp_pkg::PH_EXPECT_R: want = fcp_pkg::HDR_R;
                    default:              want = fcp_pkg::SEP_COLON;
                endcase
                // a wrong byte goes back to the hunt and is not retried as 'U'
                if (b == want)
                begin
                    sh_xor   = sh_xor ^ b;
                    sh_phase = fcp_pkg::phase_t'(sh_phase + 3'd1);
                end
                else
                begin
                    sh_phase = fcp_pkg::PH_HUNT_U;
                end
            end
            fcp_pkg::PH_LENGTH:
            begin
                sh_length = b;
                sh_xor    = sh_xor ^ b;
                sh_phase  = fcp_pkg::PH_COLON;
            end
            fcp_pkg::PH_COMMAND:
            begin
                sh_cmd    = b;
                sh_xor    = sh_xor ^ b;
                sh_left   = sh_length;
                sh_phase  = fcp_pkg::PH_BODY;
                item.kind = fcp_pkg::KIND_CMD;
                item.data = b;
                parsed_q.push_back(item);
            end
            default:
            begin
                if (sh_left != 8'd0)
                begin
                    sh_xor    = sh_xor ^ b;
                    sh_left   = sh_left - 8'd1;
                    item.kind = fcp_pkg::KIND_PAYLOAD;
                    item.data = b;
                end
                else
                begin
                    // check byte; good or bad, back to the hunt
                    sh_phase  = fcp_pkg::PH_HUNT_U;
                    item.kind = (sh_xor == b) ? fcp_pkg::KIND_GOOD : fcp_pkg::KIND_BAD;
                    item.data = sh_cmd;
                end
                parsed_q.push_back(item);
            end
        endcase
    endtask

    // Result checker: each accepted output item against the oldest expectation.
    always @(posedge clk)
    begin
        parsed_item_t want_item;
        if (rst_n && out_valid && !out_stall)
        begin
            if (parsed_q.size() == 0)
            begin
                $display("%0t: unexpected item kind=%0d data=%02h", $time, kind, data);
                errors++;
            end
            else
            begin
                want_item = parsed_q.pop_front();
                if (kind != want_item.kind)
                begin
                    $display("%0t: kind mismatch, expected %0d, actual %0d",
                             $time, want_item.kind, kind);
                    errors++;
                end
                if (data != want_item.data)
                begin
                    $display("%0t: data mismatch, expected %02h, actual %02h",
                             $time, want_item.data, data);
                    errors++;
                end
            end
        end
    end

    // Sends one byte, with an optional idle burst before it; returns once accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_parse(b);
        byte_count++;
    endtask

    // Full frame: header, length, ':', command, random payload, check byte.
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit bad_check);
        logic [7:0] chk;
        logic [7:0] pb;
        chk = fcp_pkg::HDR_U ^ fcp_pkg::HDR_N ^ fcp_pkg::HDR_E ^ fcp_pkg::HDR_R
              ^ len[7:0] ^ fcp_pkg::SEP_COLON ^ cmd;
        send_byte(fcp_pkg::HDR_U);
        send_byte(fcp_pkg::HDR_N);
        send_byte(fcp_pkg::HDR_E);
        send_byte(fcp_pkg::HDR_R);
        send_byte(len[7:0]);
        send_byte(fcp_pkg::SEP_COLON);
        send_byte(cmd);
        for (int i = 0; i < len; i++)
        begin
            pb  = 8'($urandom);
            chk = chk ^ pb;
            send_byte(pb);
        end
        if (bad_check)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Frame start cut off by a wrong byte: at 'N', 'E', 'R' or the ':' (stage 1 to 4).
    task automatic send_broken(input int stage);
        logic [7:0] want;
        logic [7:0] bad;
        send_byte(fcp_pkg::HDR_U);
        want = fcp_pkg::HDR_N;
        if (stage >= 2)
        begin
            send_byte(fcp_pkg::HDR_N);
            want = fcp_pkg::HDR_E;
        end
        if (stage >= 3)
        begin
            send_byte(fcp_pkg::HDR_E);
            want = fcp_pkg::HDR_R;
        end
        if (stage >= 4)
        begin
            send_byte(fcp_pkg::HDR_R);
            send_byte(8'($urandom));
            want = fcp_pkg::SEP_COLON;
        end
        do
            bad = 8'($urandom);
        while (bad == want);
        send_byte(bad);
    endtask

    // Idle the sender until every expected item has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (parsed_q.size() != 0)
            @(posedge clk);
    endtask

    // Extremes and special cases: noise, zero length, extreme bytes, bad check,
    // wrong header byte, wrong ':' and a 'U' that is not retried after a mismatch.
    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 0, 1'b0);
        send_byte(fcp_pkg::HDR_U);
        send_byte(fcp_pkg::HDR_U);
        send_byte(fcp_pkg::HDR_N);
        send_broken(3);
        send_broken(4);
        send_frame(8'h00, 1, 1'b1);
    endtask

    // Mostly well-formed frames with random content; some broken ones and noise.
    task automatic test_random_frames();
        int start;
        int pick;
        int len;
        int big_frames;
        start      = byte_count;
        big_frames = 0;
        while (byte_count - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 29) == 0)
                idle_en <= ~idle_en;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = $urandom_range(0, 10);
                // a few frames at the largest length
                if (big_frames < 2 && $urandom_range(0, 39) == 0)
                begin
                    len = 255;
                    big_frames++;
                end
                send_frame(8'($urandom), len, $urandom_range(0, 4) == 0);
            end
            else if (pick < 85)
            begin
                send_broken($urandom_range(1, 4));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
        end
        idle_en <= 1'b1;
    endtask

    // Sender holds off until the scoreboard is empty, then resumes mid-stream.
    task automatic test_drain_pause();
        send_frame(8'($urandom), 3, 1'b0);
        wait_drained();
        send_frame(8'($urandom), 2, 1'b1);
        send_broken(1);
        send_broken(2);
    endtask

    // Back-to-back stream with no idling on either side.
    task automatic test_steady_stream();
        int start;
        idle_en <= 1'b0;
        start = byte_count;
        while (byte_count - start < STEADY_ITEMS)
            send_frame(8'($urandom), $urandom_range(0, 6), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        sh_phase  = fcp_pkg::PH_HUNT_U;
        sh_length = 8'h00;
        sh_left   = 8'h00;
        sh_xor    = 8'h00;
        sh_cmd    = 8'h00;

        repeat (12) @(posedge clk);
        rst_n   <= 1'b1;
        idle_en <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_frames();
        test_drain_pause();
        test_steady_stream();

        // let the pipeline empty, then idle before the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
